@@ sv/assert_macros.svh @@
// Assertion macros for the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/tils_pkg.sv @@
// Types and constants of the turn indicator LED sequencer.
package tils_pkg;

    typedef enum logic [2:0] {
        MODE_TICK        = 3'd0,
        MODE_KNOB        = 3'd1,
        MODE_BUTTON      = 3'd2,
        MODE_LEFT_STYLE  = 3'd3,
        MODE_RIGHT_STYLE = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [9:0] knob;
        logic       button_level;
        logic       running_light;
        logic       strip;
        logic       direction;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] left_leds;
        logic [7:0] right_leds;
        logic       relay;
        logic       stopped;
    } out_beat_t;

    typedef struct packed {
        logic direction;
        logic strip;
        logic running_light;
    } style_t;

    // knob*3000/1023: 1023 is divided out by multiplying by 3000*1025 / 2^20
    localparam logic [11:0] KNOB_SCALE      = 12'd3000;
    localparam logic [21:0] KNOB_SCALE_RECIP = 22'd3075000;
    localparam logic [10:0] KNOB_FULL       = 11'd1023;
    localparam int          KNOB_SHIFT      = 20;

    // (q + 1000) / 54 via 1213 / 2^16, then one correction
    localparam logic [11:0] PERIOD_OFFSET   = 12'd1000;
    localparam logic [10:0] STEP_DIV_RECIP  = 11'd1213;
    localparam logic [11:0] STEP_DIV        = 12'd54;
    localparam int          STEP_DIV_SHIFT  = 16;

    localparam logic [3:0]  PHASE_LAST      = 4'd8;
    localparam logic [3:0]  RELAY_PHASES    = 4'd4;
    localparam logic [6:0]  ELAPSED_MAX     = 7'd127;

endpackage

@@ sv/turn_indicator_led_sequencer.sv @@
// Turn indicator LED sequencer: two LED strips and a relay stepped by 1 ms ticks.
// A result reaches m_data through the input register and then the result register.
// Throughput: one input beat per cycle while not stalled; the input register and the result register
//   decouple the sides, so s_ready drops only when both are full and m_ready is low.
// Reset (aresetn low, synchronous): stopped, phase 0, patterns, styles, tick count
//   and step period cleared, both registers empty.
`include "assert_macros.svh"

module turn_indicator_led_sequencer
    import tils_pkg::*;
#(
    parameter int LED_COUNT = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // ------------------------------------------------------------------
    // Next pattern of one side for the current phase.
    // Plain blink: all on for phases below four.
    // Running light: cleared at phase 0, end LED set at phase 1, then
    // shifted toward the direction with the strip bit fed in.
    // ------------------------------------------------------------------
    function automatic logic [LED_COUNT-1:0] next_pattern(
        input style_t               st,
        input logic [LED_COUNT-1:0] pat,
        input logic [3:0]           ph
    );
        logic [LED_COUNT-1:0] top;
        logic [LED_COUNT-1:0] res;
        top = {1'b1, {(LED_COUNT-1){1'b0}}};
        if (!st.running_light) begin
            res = (ph < RELAY_PHASES) ? '1 : '0;
        end else if (ph == 4'd0) begin
            res = '0;
        end else if (!st.direction) begin
            if (ph == 4'd1) begin
                res = pat | LED_COUNT'(1);
            end else begin
                res = {pat[LED_COUNT-2:0], st.strip};
            end
        end else begin
            if (ph == 4'd1) begin
                res = pat | top;
            end else begin
                res = {st.strip, pat[LED_COUNT-1:1]};
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Front end: first half of the step period arithmetic.
    // q = floor(knob*3000/1023). The reciprocal product underestimates by
    // at most one, fixed by a single remainder compare.
    // ------------------------------------------------------------------
    logic [21:0] knob_scaled;
    logic [31:0] knob_recip;
    logic [11:0] knob_q0;
    logic [21:0] knob_q0_x;
    logic [21:0] knob_rem;
    logic [11:0] knob_quot;

    assign knob_scaled = 22'(s_data.knob) * 22'(KNOB_SCALE);
    assign knob_recip  = 32'(s_data.knob) * 32'(KNOB_SCALE_RECIP);
    assign knob_q0     = knob_recip[KNOB_SHIFT+11:KNOB_SHIFT];
    // q0 * 1023 as shift and subtract
    assign knob_q0_x   = (22'(knob_q0) << 10) - 22'(knob_q0);
    assign knob_rem    = knob_scaled - knob_q0_x;
    assign knob_quot   = (knob_rem >= 22'(KNOB_FULL)) ? knob_q0 + 12'd1 : knob_q0;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg,  in_valid_next;
    logic [2:0]  in_mode_reg;
    logic        in_level_reg;
    style_t      in_style_reg;
    logic [11:0] in_quot_reg;

    // ------------------------------------------------------------------
    // Block state and result register
    // ------------------------------------------------------------------
    logic [3:0]           phase_reg,         phase_next;
    logic [LED_COUNT-1:0] left_pattern_reg,  left_pattern_next;
    logic [LED_COUNT-1:0] right_pattern_reg, right_pattern_next;
    style_t               left_style_reg,    left_style_next;
    style_t               right_style_reg,   right_style_next;
    logic                 running_reg,       running_next;
    logic [6:0]           elapsed_reg,       elapsed_next;
    logic [6:0]           step_period_reg,   step_period_next;
    logic                 out_valid_reg,     out_valid_next;
    out_beat_t            out_data_reg,      out_data_next;

    logic                 work_fire;
    logic [6:0]           elapsed_inc;
    logic [LED_COUNT-1:0] left_step;
    logic [LED_COUNT-1:0] right_step;

    // second half of the period arithmetic: (q + 1000) / 54
    logic [11:0] period_sum;
    logic [22:0] period_recip;
    logic [6:0]  period_q0;
    logic [11:0] period_q0_x;
    logic [11:0] period_rem;
    logic [6:0]  period_quot;

    assign period_sum   = in_quot_reg + PERIOD_OFFSET;
    assign period_recip = 23'(period_sum) * 23'(STEP_DIV_RECIP);
    assign period_q0    = period_recip[STEP_DIV_SHIFT+6:STEP_DIV_SHIFT];
    // q0 * 54 = q0*64 - q0*8 - q0*2
    assign period_q0_x  = (12'(period_q0) << 6) - (12'(period_q0) << 3)
                        - (12'(period_q0) << 1);
    assign period_rem   = period_sum - period_q0_x;
    assign period_quot  = (period_rem >= STEP_DIV) ? period_q0 + 7'd1 : period_q0;

    // stage moves when the result register is free or being emptied
    assign work_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || work_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 7'd1 : elapsed_reg;
    assign left_step   = next_pattern(left_style_reg,  left_pattern_reg,  phase_reg);
    assign right_step  = next_pattern(right_style_reg, right_pattern_reg, phase_reg);

    always_comb begin
        in_valid_next      = (in_valid_reg && !work_fire) || (s_valid && s_ready);
        phase_next         = phase_reg;
        left_pattern_next  = left_pattern_reg;
        right_pattern_next = right_pattern_reg;
        left_style_next    = left_style_reg;
        right_style_next   = right_style_reg;
        running_next       = running_reg;
        elapsed_next       = elapsed_reg;
        step_period_next   = step_period_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        out_data_next      = out_data_reg;

        if (work_fire) begin
            case (in_mode_reg)
                MODE_TICK: begin
                    if (elapsed_inc < step_period_reg) begin
                        elapsed_next = elapsed_inc;
                    end else begin
                        elapsed_next = '0;
                        if (running_reg) begin
                            left_pattern_next        = left_step;
                            right_pattern_next       = right_step;
                            out_valid_next           = 1'b1;
                            out_data_next.left_leds  = 8'(left_step);
                            out_data_next.right_leds = 8'(right_step);
                            out_data_next.relay      = phase_reg < RELAY_PHASES;
                            out_data_next.stopped    = 1'b0;
                            phase_next = (phase_reg < PHASE_LAST) ? phase_reg + 4'd1 : '0;
                        end
                    end
                end
                MODE_KNOB: begin
                    step_period_next = period_quot;
                end
                MODE_BUTTON: begin
                    if (!in_level_reg) begin
                        running_next = !running_reg;
                        if (running_reg) begin
                            // stopping: clear and report all off
                            phase_next               = '0;
                            left_pattern_next        = '0;
                            right_pattern_next       = '0;
                            out_valid_next           = 1'b1;
                            out_data_next.left_leds  = '0;
                            out_data_next.right_leds = '0;
                            out_data_next.relay      = 1'b0;
                            out_data_next.stopped    = 1'b1;
                        end
                    end
                end
                MODE_LEFT_STYLE: begin
                    left_style_next = in_style_reg;
                end
                MODE_RIGHT_STYLE: begin
                    right_style_next = in_style_reg;
                end
                default: begin
                    // unknown kinds are dropped
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= '0;
            left_pattern_reg  <= '0;
            right_pattern_reg <= '0;
            left_style_reg    <= '0;
            right_style_reg   <= '0;
            running_reg       <= 1'b0;
            elapsed_reg       <= '0;
            step_period_reg   <= '0;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            phase_reg         <= phase_next;
            left_pattern_reg  <= left_pattern_next;
            right_pattern_reg <= right_pattern_next;
            left_style_reg    <= left_style_next;
            right_style_reg   <= right_style_next;
            running_reg       <= running_next;
            elapsed_reg       <= elapsed_next;
            step_period_reg   <= step_period_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg                <= s_data.mode;
            in_level_reg               <= s_data.button_level;
            in_style_reg.running_light <= s_data.running_light;
            in_style_reg.strip         <= s_data.strip;
            in_style_reg.direction     <= s_data.direction;
            in_quot_reg                <= knob_quot;
        end
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_period_range, aclk, aresetn, (step_period_reg == 7'd0) || ((step_period_reg >= 7'd18) && (step_period_reg <= 7'd74)), "step period outside knob range")
    `ASSERT_ALWAYS(a_phase_range, aclk, aresetn, phase_reg <= PHASE_LAST, "phase beyond last step")
    `ASSERT_IMPLIES(a_stop_all_off, aclk, aresetn, m_valid && m_data.stopped, (m_data.left_leds == 8'd0) && (m_data.right_leds == 8'd0) && !m_data.relay, "stop result not all off")
    `ASSERT_IMPLIES(a_ready_stall, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled without back pressure")
    `ASSERT_IMPLIES(a_result_source, aclk, aresetn, $rose(m_valid), $past(in_valid_reg), "result without an item in the input register")

endmodule

@@ bench/turn_indicator_led_sequencer_tb.sv @@
// Self-checking bench for the turn indicator LED sequencer: directed table, then random beats.
`timescale 1ns / 100ps

module turn_indicator_led_sequencer_tb
    import tils_pkg::*;
();

    // One row of the directed table. Where want_fixed is set the result is typed
    // in by hand, otherwise the sequencer model below supplies it.
    typedef struct {
        in_beat_t  beat;
        bit        want_fixed;
        out_beat_t want;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Sequencer model state, mirrors the block's registers
    logic [3:0] phase_q;
    logic [7:0] left_pat_q;
    logic [7:0] right_pat_q;
    style_t     left_style_q;
    style_t     right_style_q;
    bit         running_q;
    int         ticks_q;
    int         period_q;

    out_beat_t  pending_leds[$];   // lamp beats still owed by the block
    int         fail_count  = 0;
    bit         hold_req    = 1'b0;

    turn_indicator_led_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // Synchronous reset, released once and never again
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Generous overall limit on the length of the run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    // Next pattern of one strip for the phase being stepped
    function automatic logic [7:0] strip_step(style_t st, logic [7:0] pat, logic [3:0] ph);
        if (!st.running_light)
            return (ph < RELAY_PHASES) ? 8'hff : 8'h00;
        if (ph == 4'd0)
            return 8'h00;
        if (!st.direction) begin
            // shifting up: LED 0 is the end that gets lit and fed
            if (ph == 4'd1)
                return pat | 8'h01;
            return {pat[6:0], st.strip};
        end
        if (ph == 4'd1)
            return pat | 8'h80;
        return {st.strip, pat[7:1]};
    endfunction

    task automatic seq_reset();
        phase_q       = '0;
        left_pat_q    = '0;
        right_pat_q   = '0;
        left_style_q  = '0;
        right_style_q = '0;
        running_q     = 1'b0;
        ticks_q       = 0;
        period_q      = 0;
    endtask

    // Apply one accepted input beat; has_lamps says whether a result beat follows
    task automatic advance_sequencer(input in_beat_t b, output bit has_lamps,
                                     output out_beat_t lamps);
        int k;
        has_lamps = 1'b0;
        lamps     = '0;
        case (b.mode)
            MODE_TICK: begin
                if (ticks_q < ELAPSED_MAX)
                    ticks_q++;
                if (ticks_q >= period_q) begin
                    ticks_q = 0;
                    if (running_q) begin
                        left_pat_q       = strip_step(left_style_q, left_pat_q, phase_q);
                        right_pat_q      = strip_step(right_style_q, right_pat_q, phase_q);
                        lamps.left_leds  = left_pat_q;
                        lamps.right_leds = right_pat_q;
                        lamps.relay      = (phase_q < RELAY_PHASES);
                        has_lamps        = 1'b1;
                        phase_q          = (phase_q < PHASE_LAST) ? phase_q + 4'd1 : 4'd0;
                    end
                end
            end
            MODE_KNOB: begin
                k        = int'(b.knob);
                period_q = ((k * 3000) / 1023 + 1000) / 54;
            end
            MODE_BUTTON: begin
                // only a low level toggles; stopping yields the all-off beat
                if (!b.button_level) begin
                    running_q = !running_q;
                    if (!running_q) begin
                        phase_q       = '0;
                        left_pat_q    = '0;
                        right_pat_q   = '0;
                        lamps.stopped = 1'b1;
                        has_lamps     = 1'b1;
                    end
                end
            end
            MODE_LEFT_STYLE:  left_style_q  = {b.direction, b.strip, b.running_light};
            MODE_RIGHT_STYLE: right_style_q = {b.direction, b.strip, b.running_light};
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t row(logic [2:0] mode, int knob, bit lvl, bit rl,
                                      bit strip, bit dir, bit fixed = 1'b0,
                                      out_beat_t want = '0);
        stim_row_t r;
        r.beat.mode          = mode;
        r.beat.knob          = knob[9:0];
        r.beat.button_level  = lvl;
        r.beat.running_light = rl;
        r.beat.strip         = strip;
        r.beat.direction     = dir;
        r.want_fixed         = fixed;
        r.want               = want;
        return r;
    endfunction

    // Random beat, weighted towards ticks so the strips keep stepping.
    // While stopped, extra low button presses get the sequencer going again.
    function automatic in_beat_t rand_beat();
        in_beat_t b;
        int       pick;
        b      = in_beat_t'(17'($urandom));
        b.knob = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                             : 10'($urandom_range(0, 40));
        pick   = $urandom_range(0, 199);
        if (pick < 150)
            b.mode = MODE_TICK;
        else if (pick < 156)
            b.mode = MODE_KNOB;
        else if (pick < 159)
            b.mode = MODE_BUTTON;
        else if (pick < 172)
            b.mode = MODE_LEFT_STYLE;
        else if (pick < 185)
            b.mode = MODE_RIGHT_STYLE;
        else if (pick < 191)
            b.mode = 3'($urandom_range(5, 7));
        else if (!running_q) begin
            b.mode         = MODE_BUTTON;
            b.button_level = 1'b0;
        end else
            b.mode = MODE_TICK;
        return b;
    endfunction

    // Offer one beat until taken, then work out what the block owes for it
    task automatic send_beat(input in_beat_t b, input bit fixed, input out_beat_t want);
        bit        has_lamps;
        out_beat_t lamps;
        s_data  <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        advance_sequencer(b, has_lamps, lamps);
        if (has_lamps)
            pending_leds.push_back(fixed ? want : lamps);
    endtask

    // Sender idling: bursts of random length, random gaps between them.
    // drain drops valid and waits until every owed beat has come back.
    int burst_left = 0;

    task automatic pace(input bit drain);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 6);
        end else
            burst_left--;
        // a drain always gets a nonzero gap
        if (drain && gap == 0)
            gap = 1;
        if (drain || gap > 0)
            s_valid <= 1'b0;
        if (drain)
            while (pending_leds.size() != 0)
                @(posedge aclk);
        repeat (gap) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    initial begin : sender
        stim_row_t table_q[$];
        in_beat_t  b;
        int        counted;
        bit        hold_asked;
        bit        drained;

        seq_reset();
        counted    = 0;
        hold_asked = 1'b0;
        drained    = 1'b0;

        // Directed part. Step period is 0 after reset, so every tick steps.
        table_q.push_back(row(MODE_TICK,    0,    0, 0, 0, 0));  // stopped: no beat
        table_q.push_back(row(MODE_BUTTON,  0,    1, 0, 0, 0));  // button high ignored
        table_q.push_back(row(3'd5,         1023, 1, 1, 1, 1));  // unknown modes ignored
        table_q.push_back(row(3'd6,         0,    0, 0, 0, 0));
        table_q.push_back(row(3'd7,         1023, 1, 1, 1, 1));
        table_q.push_back(row(MODE_LEFT_STYLE,  0, 0, 0, 0, 0)); // plain blink
        table_q.push_back(row(MODE_RIGHT_STYLE, 0, 0, 1, 1, 0)); // strip, shifting up
        table_q.push_back(row(MODE_BUTTON,  0,    0, 0, 0, 0));  // start
        // first step at phase 0: left all on, right cleared, relay on
        table_q.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, 1'b1,
                              out_beat_t'({8'hff, 8'h00, 1'b1, 1'b0})));
        repeat (8) table_q.push_back(row(MODE_TICK, 0, 0, 0, 0, 0)); // phases 1..8, wrap
        table_q.push_back(row(MODE_LEFT_STYLE,  0, 0, 1, 0, 1)); // single dot, shifting down
        table_q.push_back(row(MODE_RIGHT_STYLE, 0, 0, 0, 1, 1));
        repeat (3) table_q.push_back(row(MODE_TICK, 0, 0, 0, 0, 0));
        // stop: all off, relay released
        table_q.push_back(row(MODE_BUTTON, 0, 0, 0, 0, 0, 1'b1,
                              out_beat_t'({8'h00, 8'h00, 1'b0, 1'b1})));
        table_q.push_back(row(MODE_KNOB, 1023, 0, 0, 0, 0));     // slowest rate
        table_q.push_back(row(MODE_KNOB, 0,    0, 0, 0, 0));     // fastest rate

        wait (aresetn);
        @(posedge aclk);

        foreach (table_q[i]) begin
            send_beat(table_q[i].beat, table_q[i].want_fixed, table_q[i].want);
            pace(1'b0);
        end

        // Random part: about 600 beats that the block acts on
        while (counted < 600) begin
            b = rand_beat();
            send_beat(b, 1'b0, '0);
            if (!(b.mode > MODE_RIGHT_STYLE || (b.mode == MODE_BUTTON && b.button_level)))
                counted++;
            // long receiver hold-off while we keep offering: block fills and stalls
            if (counted == 150 && !hold_asked) begin
                hold_req   = 1'b1;
                hold_asked = 1'b1;
            end
            if (counted == 300 && !drained) begin
                drained = 1'b1;
                pace(1'b1);
            end else
                pace(1'b0);
        end

        pace(1'b1);
        repeat (10) @(posedge aclk);   // room for any stray beat after the last one
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: held off right after reset, then its own stall pattern,
    // plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall_kind;
        int span;
        span = 0;
        stall_kind = 0;
        wait (aresetn);
        // directed run-phase ticks each step the strips here, so this backs the block up
        repeat (150) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    stall_kind = $urandom_range(0, 2);
                    span       = $urandom_range(16, 96);
                end
                span--;
                case (stall_kind)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted lamp beat against the oldest owed one
    // ------------------------------------------------------------------
    initial begin : lamp_check
        out_beat_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_leds.size() == 0) begin
                    $error("unexpected lamp beat %h", m_data);
                    fail_count++;
                end else begin
                    want = pending_leds.pop_front();
                    if (m_data.left_leds !== want.left_leds) begin
                        $error("left_leds: expected %h, got %h", want.left_leds, m_data.left_leds);
                        fail_count++;
                    end
                    if (m_data.right_leds !== want.right_leds) begin
                        $error("right_leds: expected %h, got %h",
                               want.right_leds, m_data.right_leds);
                        fail_count++;
                    end
                    if (m_data.relay !== want.relay) begin
                        $error("relay: expected %b, got %b", want.relay, m_data.relay);
                        fail_count++;
                    end
                    if (m_data.stopped !== want.stopped) begin
                        $error("stopped: expected %b, got %b", want.stopped, m_data.stopped);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/tils_pkg.sv
sv/turn_indicator_led_sequencer.sv
bench/turn_indicator_led_sequencer_tb.sv
